/* rtl/core/cdte_pkg.sv */
// cdte_pkg: types, constants and lookup functions for the civil date to epoch seconds block
// no dependencies; imported by the channel interfaces and every rtl/core module
package cdte_pkg;

    // pipeline depth: one valid bit per register stage
    localparam int NSTAGE = 6;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int EPOCH_W = 38;

    // internal widths
    localparam int PROD_W  = 28;  // yy times reciprocal of 100
    localparam int CENT_W  = 8;   // yy / 100
    localparam int ERA_W   = 6;   // yy / 400
    localparam int YOE_W   = 9;   // year of era, 0..399
    localparam int DOY_W   = 9;   // day of year from March, 0..365
    localparam int DOE_W   = 18;  // day of era, below 146097
    localparam int EDAY_W  = 24;  // era times days per era
    localparam int DAYS_W  = 24;  // days since the epoch
    localparam int TOD_W   = 17;  // second of the day

    // reciprocal of 100: floor(x / 100) == (x * RECIP100) >> RECIP100_SH for x < 2^14
    localparam logic [13:0] RECIP100    = 14'd10486;
    localparam int          RECIP100_SH = 20;

    // calendar constants
    localparam logic [YEAR_W-1:0]  YEAR_MIN       = 14'd1970;
    localparam logic [YEAR_W-1:0]  YEAR_MAX       = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
    localparam logic [HOUR_W-1:0]  HOUR_MAX       = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_MAX        = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_MAX        = 6'd59;
    localparam logic [13:0]        YEARS_PER_ERA  = 14'd400;
    localparam logic [13:0]        YEARS_PER_CENT = 14'd100;
    localparam logic [6:0]         CENT_LAST_YEAR = 7'd99;
    localparam logic [DOE_W-1:0]   DAYS_PER_YEAR  = 18'd365;
    localparam logic [EDAY_W-1:0]  DAYS_PER_ERA   = 24'd146097;
    localparam logic [DAYS_W-1:0]  EPOCH_SHIFT    = 24'd719468;
    localparam logic [EPOCH_W-1:0] SECS_PER_DAY   = 38'd86400;
    localparam logic [TOD_W-1:0]   SECS_PER_HOUR  = 17'd3600;
    localparam logic [TOD_W-1:0]   SECS_PER_MIN   = 17'd60;

    // request and response payloads
    typedef struct packed {
        logic [YEAR_W-1:0]  calendar_year;
        logic [MONTH_W-1:0] month_of_year;
        logic [DAY_W-1:0]   day_of_month;
        logic [HOUR_W-1:0]  hour_of_day;
        logic [MIN_W-1:0]   minute_of_hour;
        logic [SEC_W-1:0]   second_of_minute;
    } t_req;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch_seconds;
        logic               date_valid;
    } t_rsp;

    // front end to day counter
    typedef struct packed {
        logic               ok;
        logic [ERA_W-1:0]   era;
        logic [YOE_W-1:0]   yoe;
        logic [1:0]         yoe_cent;
        logic [DOY_W-1:0]   doy;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_front;

    // day counter to seconds stage
    typedef struct packed {
        logic               ok;
        logic [DAYS_W-1:0]  days;
        logic [TOD_W-1:0]   tod;
    } t_days;

    // first day of the month counted from March 1
    function automatic logic [DOY_W-1:0] f_month_start(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] v;
        case (m)
            4'd1:    v = 9'd306;
            4'd2:    v = 9'd337;
            4'd3:    v = 9'd0;
            4'd4:    v = 9'd31;
            4'd5:    v = 9'd61;
            4'd6:    v = 9'd92;
            4'd7:    v = 9'd122;
            4'd8:    v = 9'd153;
            4'd9:    v = 9'd184;
            4'd10:   v = 9'd214;
            4'd11:   v = 9'd245;
            4'd12:   v = 9'd275;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // month length in a common year
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] v;
        case (m)
            4'd2:                   v = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:     v = 5'd31;
            default:                v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/cdte_if.sv */
// cdte_if: request and response channels with valid / ready handshake
// depends on cdte_pkg for the payload types

interface cdte_req_if;
    logic            valid;
    logic            ready;
    cdte_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdte_rsp_if;
    logic            valid;
    logic            ready;
    cdte_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/cdte_front.sv */
// cdte_front: stages 1-2, field checks, leap rule and split of the year into era and year of era
// depends on cdte_pkg
module cdte_front (
    input  logic              i_clk,
    input  logic              i_en,
    input  cdte_pkg::t_req    i_req,
    output cdte_pkg::t_front  o_front
);
    import cdte_pkg::*;

    typedef struct packed {
        logic               range_ok;
        logic               is_feb;
        logic [DAY_W-1:0]   day;
        logic [DAY_W-1:0]   mlen;
        logic [YEAR_W-1:0]  yy;
        logic [PROD_W-1:0]  prod;
        logic [DOY_W-1:0]   doy;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_s1;

    t_s1              n_s1, r_s1;
    t_front           n_front, r_front;
    logic [CENT_W-1:0] w_cent;
    logic [ERA_W-1:0]  w_era;
    logic [YEAR_W-1:0] w_yoe;
    logic [YEAR_W-1:0] w_rem100;
    logic              w_leap;
    logic [DAY_W:0]    w_max_day;

    // stage 1: range checks, march-based year, table lookups, year / 100 product
    always_comb begin
        n_s1.range_ok = (i_req.calendar_year >= YEAR_MIN) && (i_req.calendar_year <= YEAR_MAX)
                     && (i_req.month_of_year >= MONTH_JAN) && (i_req.month_of_year <= MONTH_DEC)
                     && (i_req.hour_of_day <= HOUR_MAX) && (i_req.minute_of_hour <= MIN_MAX)
                     && (i_req.second_of_minute <= SEC_MAX) && (i_req.day_of_month != '0);
        n_s1.is_feb = (i_req.month_of_year == MONTH_FEB);
        n_s1.day    = i_req.day_of_month;
        n_s1.mlen   = f_month_len(i_req.month_of_year);
        n_s1.yy     = i_req.calendar_year
                    - {{(YEAR_W-1){1'b0}}, (i_req.month_of_year <= MONTH_FEB)};
        n_s1.prod   = PROD_W'(n_s1.yy) * PROD_W'(RECIP100);
        n_s1.doy    = f_month_start(i_req.month_of_year)
                    + DOY_W'(i_req.day_of_month) - DOY_W'(1);
        n_s1.hour   = i_req.hour_of_day;
        n_s1.minute = i_req.minute_of_hour;
        n_s1.second = i_req.second_of_minute;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: century and era, leap rule on the calendar year, day check
    // for february yy is year - 1, so the year is a multiple of 4, 100, 400
    // exactly when yy mod 4 is 3, yy mod 100 is 99 and the century count mod 4 is 3
    always_comb begin
        w_cent    = r_s1.prod[RECIP100_SH +: CENT_W];
        w_era     = w_cent[CENT_W-1:2];
        w_yoe     = r_s1.yy - YEAR_W'({{(YEAR_W-ERA_W){1'b0}}, w_era} * YEARS_PER_ERA);
        w_rem100  = r_s1.yy - YEAR_W'({{(YEAR_W-CENT_W){1'b0}}, w_cent} * YEARS_PER_CENT);
        w_leap    = r_s1.is_feb && (r_s1.yy[1:0] == 2'b11)
                 && ((w_rem100[6:0] != CENT_LAST_YEAR) || (w_cent[1:0] == 2'b11));
        w_max_day = {1'b0, r_s1.mlen} + {{DAY_W{1'b0}}, w_leap};

        n_front.ok       = r_s1.range_ok && ({1'b0, r_s1.day} <= w_max_day);
        n_front.era      = w_era;
        n_front.yoe      = w_yoe[YOE_W-1:0];
        n_front.yoe_cent = w_cent[1:0];
        n_front.doy      = r_s1.doy;
        n_front.hour     = r_s1.hour;
        n_front.minute   = r_s1.minute;
        n_front.second   = r_s1.second;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

/* rtl/core/cdte_days.sv */
// cdte_days: stages 3-4, day of era, era days and day count since the epoch, second of day
// depends on cdte_pkg
module cdte_days (
    input  logic              i_clk,
    input  logic              i_en,
    input  cdte_pkg::t_front  i_front,
    output cdte_pkg::t_days   o_days
);
    import cdte_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [EDAY_W-1:0]  era_days;
        logic [DOE_W-1:0]   doe;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
    } t_s3;

    t_s3    n_s3, r_s3;
    t_days  n_days, r_days;

    // stage 3: day of era and era start in days
    always_comb begin
        n_s3.ok       = i_front.ok;
        n_s3.era_days = EDAY_W'(i_front.era) * DAYS_PER_ERA;
        n_s3.doe      = DOE_W'(i_front.yoe) * DAYS_PER_YEAR
                      + DOE_W'(i_front.yoe[YOE_W-1:2])
                      - DOE_W'(i_front.yoe_cent)
                      + DOE_W'(i_front.doy);
        n_s3.hour     = i_front.hour;
        n_s3.minute   = i_front.minute;
        n_s3.second   = i_front.second;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3 <= n_s3;
        end
    end

    // stage 4: days since the epoch and second of the day
    always_comb begin
        n_days.ok   = r_s3.ok;
        n_days.days = DAYS_W'(r_s3.era_days) + DAYS_W'(r_s3.doe) - EPOCH_SHIFT;
        n_days.tod  = TOD_W'(r_s3.hour) * SECS_PER_HOUR
                    + TOD_W'(r_s3.minute) * SECS_PER_MIN
                    + TOD_W'(r_s3.second);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_days <= n_days;
        end
    end

    assign o_days = r_days;

endmodule

/* rtl/core/cdte_secs.sv */
// cdte_secs: stages 5-6, day count to seconds and final sum with invalid-date zeroing
// depends on cdte_pkg
module cdte_secs (
    input  logic             i_clk,
    input  logic             i_en,
    input  cdte_pkg::t_days  i_days,
    output cdte_pkg::t_rsp   o_rsp
);
    import cdte_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [EPOCH_W-1:0] day_secs;
        logic [TOD_W-1:0]   tod;
    } t_s5;

    t_s5   n_s5, r_s5;
    t_rsp  n_rsp, r_rsp;

    // stage 5: whole days in seconds
    always_comb begin
        n_s5.ok       = i_days.ok;
        n_s5.day_secs = EPOCH_W'(i_days.days) * SECS_PER_DAY;
        n_s5.tod      = i_days.tod;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s5 <= n_s5;
        end
    end

    // stage 6: add time of day, zero for an invalid date
    always_comb begin
        n_rsp.date_valid    = r_s5.ok;
        n_rsp.epoch_seconds = r_s5.ok ? (r_s5.day_secs + EPOCH_W'(r_s5.tod)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

/* rtl/core/civil_date_to_epoch_seconds.sv */
// civil_date_to_epoch_seconds: UTC calendar date and time to Unix epoch seconds
// pipeline: six register stages lie between request and response
// throughput: one request per cycle; a stalled response freezes the whole pipeline
// reset: synchronous active-low i_rst_n clears the stage valid bits, payload is not reset
// depends on cdte_pkg, cdte_if, cdte_front, cdte_days, cdte_secs
module civil_date_to_epoch_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdte_req_if.sink    i_req,
    cdte_rsp_if.source  o_rsp
);
    import cdte_pkg::*;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic              w_adv;
    t_front            w_front;
    t_days             w_days;
    t_rsp              w_rsp;

    // pipeline moves unless the last stage holds a response not yet taken
    assign w_adv       = !r_vld[NSTAGE-1] || o_rsp.ready;
    assign i_req.ready = w_adv;

    // valid bits travel with the data
    always_comb begin
        n_vld = r_vld;
        if (w_adv) begin
            n_vld = {r_vld[NSTAGE-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    cdte_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_req   (i_req.data),
        .o_front (w_front)
    );

    cdte_days u_days (
        .i_clk   (i_clk),
        .i_en    (w_adv),
        .i_front (w_front),
        .o_days  (w_days)
    );

    cdte_secs u_secs (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_days (w_days),
        .o_rsp  (w_rsp)
    );

    assign o_rsp.valid = r_vld[NSTAGE-1];
    assign o_rsp.data  = w_rsp;

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for civil_date_to_epoch_seconds, directed corners then random dates
// depends on cdte_pkg, cdte_if and the rtl/core modules; carries its own date-to-seconds predictor
`timescale 1ns / 1ps

module tb_top;

    import cdte_pkg::t_req;
    import cdte_pkg::t_rsp;

    localparam int unsigned FIRST_YEAR     = 1970;
    localparam int unsigned LAST_YEAR      = 9999;
    localparam int unsigned FEBRUARY       = 2;
    localparam int unsigned DECEMBER       = 12;
    localparam int unsigned LAST_HOUR      = 23;
    localparam int unsigned LAST_MINUTE    = 59;
    localparam int unsigned LAST_SECOND    = 59;
    localparam longint unsigned DAYS_PER_400Y  = 146097;
    localparam longint unsigned DAYS_TO_EPOCH  = 719468;
    localparam longint unsigned SECS_PER_DAY   = 86400;
    localparam longint unsigned SECS_PER_HOUR  = 3600;
    localparam longint unsigned SECS_PER_MIN   = 60;

    localparam int N_RANDOM    = 1750;
    localparam int IDLE_PCT    = 28;
    localparam int SEND_FULL_LO = 1000;   // sender never idles in this cycle window
    localparam int SEND_FULL_HI = 1800;
    localparam int RECV_FULL_LO = 2000;   // receiver never stalls in this cycle window
    localparam int RECV_FULL_HI = 2600;
    localparam int HOLD_AT     = 1200;
    localparam int HOLD_LEN    = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct {
        t_rsp rsp;
        int   stamp;
    } predicted_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drv_valid = 1'b0;
    t_req drv_data = '0;
    logic rsp_ready = 1'b0;

    t_req       pending_dates[$];
    predicted_t predicted_epochs[$];

    int cycle = 0;
    int n_errors = 0;
    int n_sent = 0;
    int n_valid_dates = 0;
    int n_rejected = 0;
    int n_input_stalls = 0;
    int hold_left = 0;

    cdte_req_if req_ch ();
    cdte_rsp_if rsp_ch ();

    assign req_ch.valid = drv_valid;
    assign req_ch.data  = drv_data;
    assign rsp_ch.ready = rsp_ready;

    civil_date_to_epoch_seconds dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // free-running cycle count and run limit
    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle, predicted_epochs.size());
            $display("FAILURE");
            $finish;
        end
    end

    // gregorian month length, february gets 29 days in leap years
    function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mon);
        int unsigned len;
        case (mon)
            FEBRUARY:       len = 28;
            4, 6, 9, 11:    len = 30;
            default:        len = 31;
        endcase
        if (mon == FEBRUARY && (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0)))
            len = 29;
        return len;
    endfunction

    // expected seconds since the epoch, zero with the flag clear for a bad date
    function automatic t_rsp civil_to_epoch(input t_req r);
        int unsigned yr, mon, dd, yy, era, yoe, mp, doy, doe;
        longint unsigned days, secs;
        t_rsp res;
        res = '0;
        yr  = r.calendar_year;
        mon = r.month_of_year;
        dd  = r.day_of_month;
        if (yr < FIRST_YEAR || yr > LAST_YEAR || mon < 1 || mon > DECEMBER ||
            r.hour_of_day > LAST_HOUR || r.minute_of_hour > LAST_MINUTE ||
            r.second_of_minute > LAST_SECOND)
            return res;
        if (dd == 0 || dd > days_in_month(yr, mon))
            return res;
        // year starts on march 1, counted in 400-year eras
        yy   = (mon <= FEBRUARY) ? yr - 1 : yr;
        era  = yy / 400;
        yoe  = yy - era * 400;
        mp   = (mon > FEBRUARY) ? mon - 3 : mon + 9;
        doy  = (153 * mp + 2) / 5 + dd - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        days = longint'(era) * DAYS_PER_400Y + longint'(doe) - DAYS_TO_EPOCH;
        secs = days * SECS_PER_DAY + longint'(r.hour_of_day) * SECS_PER_HOUR
             + longint'(r.minute_of_hour) * SECS_PER_MIN + longint'(r.second_of_minute);
        res.epoch_seconds = secs[37:0];
        res.date_valid    = 1'b1;
        return res;
    endfunction

    task automatic add_date(input int unsigned yr, input int unsigned mon, input int unsigned dd,
                            input int unsigned hh, input int unsigned mi, input int unsigned ss);
        t_req r;
        r.calendar_year    = yr[13:0];
        r.month_of_year    = mon[3:0];
        r.day_of_month     = dd[4:0];
        r.hour_of_day      = hh[4:0];
        r.minute_of_hour   = mi[5:0];
        r.second_of_minute = ss[5:0];
        pending_dates.push_back(r);
    endtask

    // zero, the last legal value, one past it, or anything in range
    function automatic int unsigned near_limit(input int unsigned top);
        int unsigned v;
        case ($urandom_range(3))
            0:       v = 0;
            1:       v = top;
            2:       v = top + 1;
            default: v = $urandom_range(top);
        endcase
        return v;
    endfunction

    // request driver
    always @(posedge clk) begin : drive_requests
        logic send_gap;
        predicted_t p;
        if (!rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && req_ch.ready) begin
                p.rsp   = civil_to_epoch(drv_data);
                p.stamp = cycle;
                predicted_epochs.push_back(p);
                n_sent++;
            end
            if (drv_valid && !req_ch.ready)
                n_input_stalls++;
            if (!drv_valid || req_ch.ready) begin
                send_gap = !(cycle >= SEND_FULL_LO && cycle < SEND_FULL_HI) &&
                           ($urandom_range(99) < IDLE_PCT);
                if (pending_dates.size() != 0 && !send_gap) begin
                    drv_valid <= 1'b1;
                    drv_data  <= pending_dates.pop_front();
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor with random stalls and one long hold-off
    always @(posedge clk) begin : check_responses
        predicted_t p;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ready) begin
                // entries stamped this cycle belong to requests taken at this same edge
                if (predicted_epochs.size() == 0 || predicted_epochs[0].stamp >= cycle) begin
                    $display("%0t: unexpected response, actual seconds %0d valid %0b",
                             $time, rsp_ch.data.epoch_seconds, rsp_ch.data.date_valid);
                    n_errors++;
                end else begin
                    p = predicted_epochs.pop_front();
                    if (rsp_ch.data.epoch_seconds !== p.rsp.epoch_seconds) begin
                        $display("%0t: epoch_seconds mismatch, expected %0d actual %0d",
                                 $time, p.rsp.epoch_seconds, rsp_ch.data.epoch_seconds);
                        n_errors++;
                    end
                    if (rsp_ch.data.date_valid !== p.rsp.date_valid) begin
                        $display("%0t: date_valid mismatch, expected %0b actual %0b",
                                 $time, p.rsp.date_valid, rsp_ch.data.date_valid);
                        n_errors++;
                    end
                    if (p.rsp.date_valid)
                        n_valid_dates++;
                    else
                        n_rejected++;
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end else if (cycle == HOLD_AT) begin
                hold_left <= HOLD_LEN;
                rsp_ready <= 1'b0;
            end else begin
                rsp_ready <= (cycle >= RECV_FULL_LO && cycle < RECV_FULL_HI) ||
                             ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        int unsigned yr, mon, dim;
        int kind;

        // directed corners
        add_date(FIRST_YEAR, 1, 1, 0, 0, 0);
        add_date(LAST_YEAR, DECEMBER, 31, LAST_HOUR, LAST_MINUTE, LAST_SECOND);
        add_date(FIRST_YEAR - 1, DECEMBER, 31, LAST_HOUR, LAST_MINUTE, LAST_SECOND);
        add_date(LAST_YEAR + 1, 1, 1, 0, 0, 0);
        add_date(0, 0, 0, 0, 0, 0);
        add_date(16383, 15, 31, 31, 63, 63);
        add_date(2000, 0, 10, 12, 0, 0);
        add_date(2000, 13, 10, 12, 0, 0);
        add_date(2000, 15, 10, 12, 0, 0);
        add_date(2000, 1, 0, 12, 0, 0);
        add_date(2000, 1, 31, 12, 0, 0);
        add_date(2001, 4, 31, 12, 0, 0);
        add_date(2000, FEBRUARY, 29, 1, 2, 3);
        add_date(2024, FEBRUARY, 29, 1, 2, 3);
        add_date(2023, FEBRUARY, 29, 1, 2, 3);
        add_date(2100, FEBRUARY, 29, 1, 2, 3);
        add_date(2000, FEBRUARY, 30, 1, 2, 3);
        add_date(2100, FEBRUARY, 28, 1, 2, 3);
        add_date(2038, 1, 19, 3, 14, 7);
        add_date(2020, 6, 15, LAST_HOUR + 1, 0, 0);
        add_date(2020, 6, 15, 31, 0, 0);
        add_date(2020, 6, 15, 0, LAST_MINUTE + 1, 0);
        add_date(2020, 6, 15, 0, 63, 0);
        add_date(2020, 6, 15, 0, 0, LAST_SECOND + 1);
        add_date(2020, 6, 15, 0, 0, 63);

        // random part: mostly legal dates, then corners, then raw noise
        for (int i = 0; i < N_RANDOM; i++) begin
            kind = $urandom_range(99);
            if (kind < 60) begin
                yr  = $urandom_range(LAST_YEAR, FIRST_YEAR);
                mon = $urandom_range(DECEMBER, 1);
                dim = days_in_month(yr, mon);
                add_date(yr, mon, $urandom_range(dim, 1), $urandom_range(LAST_HOUR),
                         $urandom_range(LAST_MINUTE), $urandom_range(LAST_SECOND));
            end else if (kind < 78) begin
                case ($urandom_range(5))
                    0:       yr = FIRST_YEAR + $urandom_range(3);
                    1:       yr = LAST_YEAR - $urandom_range(3);
                    2:       yr = 100 * $urandom_range(99, 20);
                    3:       yr = 4 * $urandom_range(2499, 493);
                    4:       yr = $urandom_range(1) ? FIRST_YEAR - 1 : LAST_YEAR + 1;
                    default: yr = 400 * $urandom_range(24, 5);
                endcase
                mon = $urandom_range(DECEMBER, 1);
                dim = days_in_month(yr, mon);
                add_date(yr, mon, near_limit(dim), near_limit(LAST_HOUR),
                         near_limit(LAST_MINUTE), near_limit(LAST_SECOND));
            end else begin
                add_date($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_dates.size() != 0 || drv_valid || predicted_epochs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d requests: %0d legal dates, %0d rejected", n_sent,
                 n_valid_dates, n_rejected);
        $display("input held back by a full pipeline on %0d cycles, one %0d-cycle output hold-off",
                 n_input_stalls, HOLD_LEN);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
